FILE: rtl/triangle_scanline_fill_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the triangle span generator
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_SCANLINE_FILL_CORE_DEFINES_SVH
`define TRIANGLE_SCANLINE_FILL_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define TSF_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define TSF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/tsf_pkg.sv
// ----------------------------------------------------------------------------
// tsf_pkg
// Widths, codes and transfer types shared by the triangle span generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tsf_pkg;

   localparam int COORD_BITS = 12;
   localparam int FRAC_BITS  = 16;
   localparam int COLOUR_W   = 32;

   // coordinate difference
   localparam int DIFF_W    = COORD_BITS + 1;
   // fixed-point edge position and slope
   localparam int POS_W     = COORD_BITS + FRAC_BITS + 1;
   // split-point product and its accumulated sum
   localparam int MUL_W     = 2 * DIFF_W;
   localparam int ACC_W     = MUL_W + 1;
   // divider dividend / quotient, wide enough for both uses
   localparam int DIV_NUM_W = (POS_W > ACC_W) ? POS_W : ACC_W;
   localparam int DIV_DEN_W = DIFF_W;

   typedef enum logic {
      ACT_START   = 1'b0,
      ACT_ADVANCE = 1'b1
   } tsf_action_type;

   typedef struct packed {
      tsf_action_type                action;
      logic signed [COORD_BITS-1:0]  ax;
      logic signed [COORD_BITS-1:0]  ay;
      logic signed [COORD_BITS-1:0]  bx;
      logic signed [COORD_BITS-1:0]  by;
      logic signed [COORD_BITS-1:0]  cx;
      logic signed [COORD_BITS-1:0]  cy;
      logic        [COLOUR_W-1:0]    fill_colour;
   } tsf_req_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0]  row;
      logic signed [COORD_BITS-1:0]  edge_a_x;
      logic signed [COORD_BITS-1:0]  edge_b_x;
      logic        [COLOUR_W-1:0]    span_colour;
      logic                          final_span;
   } tsf_rsp_type;

endpackage

`default_nettype wire

FILE: rtl/tsf_div.sv
// ----------------------------------------------------------------------------
// tsf_div
// Signed restoring divider, one quotient bit per cycle, truncates toward
// zero. A zero divisor gives a zero quotient.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsf_div
   import tsf_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic signed [DIV_NUM_W-1:0] dividend,
   input  logic signed [DIV_DEN_W-1:0] divisor,
   output logic                        done,
   output logic signed [DIV_NUM_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIV_NUM_W);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic                 neg_ff, neg_in;
   logic                 zero_ff, zero_in;
   logic [DIV_DEN_W:0]   rem_sh;
   logic [DIV_DEN_W:0]   diff;
   logic                 last_step;

   assign rem_sh    = {rem_ff, quo_ff[DIV_NUM_W-1]};
   assign diff      = rem_sh - {1'b0, den_ff};
   assign last_step = (cnt_ff == CNT_W'(DIV_NUM_W - 1));

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      neg_in  = neg_ff;
      zero_in = zero_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend[DIV_NUM_W-1] ? DIV_NUM_W'(-dividend) : DIV_NUM_W'(dividend);
         den_in  = divisor[DIV_DEN_W-1] ? DIV_DEN_W'(-divisor) : DIV_DEN_W'(divisor);
         neg_in  = dividend[DIV_NUM_W-1] ^ divisor[DIV_DEN_W-1];
         zero_in = (divisor == '0);
      end else if (busy_ff) begin
         // remainder stays below the divisor, so it fits its width
         rem_in = diff[DIV_DEN_W] ? rem_sh[DIV_DEN_W-1:0] : diff[DIV_DEN_W-1:0];
         quo_in = {quo_ff[DIV_NUM_W-2:0], ~diff[DIV_DEN_W]};
         cnt_in = cnt_ff + CNT_W'(1);
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
   end

   assign done     = done_ff;
   assign quotient = zero_ff ? '0 : (neg_ff ? $signed(-quo_ff) : $signed(quo_ff));

endmodule

`default_nettype wire

FILE: rtl/triangle_scanline_fill_core.sv
// ----------------------------------------------------------------------------
// triangle_scanline_fill_core
// Scanline triangle span generator: sorts the vertices, derives fixed-point
// edge slopes with a shared serial divider and walks the rows one span per
// advance transfer.
//
//   channel | direction | payload       | handshake
//   --------+-----------+---------------+-----------------------
//   req     | in        | tsf_req_type  | req_valid / req_stall
//   rsp     | out       | tsf_rsp_type  | rsp_valid / rsp_stall
//
// A start transfer is followed by a setup during which req_stall is high:
// two slope divisions for a triangle with a flat side, plus a split-point
// division for a general one, each of DIV_NUM_W (29) divider steps. Crossing
// the middle row repeats the slope setup. Once set up, one span per cycle;
// a held span in the output register stalls further advance transfers only
// while rsp_stall is high.
// Reset is synchronous and leaves the block idle with no triangle loaded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "triangle_scanline_fill_core_defines.svh"

module triangle_scanline_fill_core
   import tsf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  tsf_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output tsf_rsp_type rsp_data
);

   typedef enum logic [11:0] {
      ST_IDLE    = 12'b0000_0000_0001,
      ST_SORT    = 12'b0000_0000_0010,
      ST_PLAN    = 12'b0000_0000_0100,
      ST_MUL1    = 12'b0000_0000_1000,
      ST_MUL2    = 12'b0000_0001_0000,
      ST_SPLIT   = 12'b0000_0010_0000,
      ST_WAIT_S  = 12'b0000_0100_0000,
      ST_SLOPE_A = 12'b0000_1000_0000,
      ST_WAIT_A  = 12'b0001_0000_0000,
      ST_SLOPE_B = 12'b0010_0000_0000,
      ST_WAIT_B  = 12'b0100_0000_0000,
      ST_ACTIVE  = 12'b1000_0000_0000
   } tsf_state_type;

   typedef enum logic [1:0] {
      MODE_UPPER_ONLY  = 2'd0,
      MODE_LOWER_ONLY  = 2'd1,
      MODE_SPLIT_UPPER = 2'd2,
      MODE_SPLIT_LOWER = 2'd3
   } tsf_mode_type;

   tsf_state_type                state_ff, state_in;
   tsf_mode_type                 mode_ff, mode_in;
   logic                         last_part_ff, last_part_in;
   logic signed [COORD_BITS-1:0] vx_ff [3];
   logic signed [COORD_BITS-1:0] vx_in [3];
   logic signed [COORD_BITS-1:0] vy_ff [3];
   logic signed [COORD_BITS-1:0] vy_in [3];
   logic        [COLOUR_W-1:0]   colour_ff, colour_in;
   logic signed [COORD_BITS-1:0] split_x_ff, split_x_in;
   logic signed [ACC_W-1:0]      acc_ff, acc_in;
   logic signed [POS_W-1:0]      pos_a_ff, pos_a_in;
   logic signed [POS_W-1:0]      pos_b_ff, pos_b_in;
   logic signed [POS_W-1:0]      slope_a_ff, slope_a_in;
   logic signed [POS_W-1:0]      slope_b_ff, slope_b_in;
   logic signed [COORD_BITS-1:0] row_ff, row_in;
   logic signed [COORD_BITS-1:0] end_row_ff, end_row_in;
   logic                         row_down_ff, row_down_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   tsf_rsp_type                  rsp_data_ff, rsp_data_in;

   // sorting network
   logic signed [COORD_BITS-1:0] srt_x [3];
   logic signed [COORD_BITS-1:0] srt_y [3];
   logic signed [COORD_BITS-1:0] tmp_x, tmp_y;

   // slope operand selection
   logic                         pick_b;
   logic signed [COORD_BITS-1:0] dx_m, dx_s, dy_m, dy_s;
   logic signed [COORD_BITS-1:0] start_x, start_row, stop_row;
   logic                         walk_down;
   logic signed [DIFF_W-1:0]     slope_dx, slope_dy;

   // split point and shared units
   logic                         mul_first;
   logic signed [DIFF_W-1:0]     mul_a, mul_b;
   logic signed [MUL_W-1:0]      mul_prod;
   logic signed [DIFF_W-1:0]     split_den;
   logic                         div_start, div_done;
   logic signed [DIV_NUM_W-1:0]  div_num, div_quo;
   logic signed [DIV_DEN_W-1:0]  div_den;

   logic                         req_fire, start_fire, span_fire, last_row;

   function automatic logic signed [COORD_BITS-1:0] pos_to_x(
      input logic signed [POS_W-1:0] p
   );
      logic adj;
      // shift rounds down; step back up for negative values with a fraction
      adj = p[POS_W-1] & (|p[FRAC_BITS-1:0]);
      return $signed(p[FRAC_BITS +: COORD_BITS] + COORD_BITS'(adj));
   endfunction

   assign req_stall  = !((state_ff == ST_IDLE) || (state_ff == ST_ACTIVE)) ||
                       (rsp_valid_ff && rsp_stall);
   assign req_fire   = req_valid && !req_stall;
   assign start_fire = req_fire && (req_data.action == ACT_START);
   assign span_fire  = req_fire && (req_data.action == ACT_ADVANCE) &&
                       (state_ff == ST_ACTIVE);
   assign last_row   = (row_ff == end_row_ff);

   // sort by y ascending, then swap ends so index 0 holds the largest y
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         srt_x[i] = vx_ff[i];
         srt_y[i] = vy_ff[i];
      end
      tmp_x = '0;
      tmp_y = '0;
      if (srt_y[0] > srt_y[1]) begin
         tmp_x = srt_x[0]; srt_x[0] = srt_x[1]; srt_x[1] = tmp_x;
         tmp_y = srt_y[0]; srt_y[0] = srt_y[1]; srt_y[1] = tmp_y;
      end
      if (srt_y[1] > srt_y[2]) begin
         tmp_x = srt_x[1]; srt_x[1] = srt_x[2]; srt_x[2] = tmp_x;
         tmp_y = srt_y[1]; srt_y[1] = srt_y[2]; srt_y[2] = tmp_y;
         if (srt_y[0] > srt_y[1]) begin
            tmp_x = srt_x[0]; srt_x[0] = srt_x[1]; srt_x[1] = tmp_x;
            tmp_y = srt_y[0]; srt_y[0] = srt_y[1]; srt_y[1] = tmp_y;
         end
      end
   end

   // edge endpoints for the slope being set up; upper parts walk down from P0
   assign pick_b = (state_ff == ST_SLOPE_B);

   always_comb begin
      dx_m      = vx_ff[0];
      dx_s      = vx_ff[1];
      dy_m      = vy_ff[1];
      dy_s      = vy_ff[0];
      start_x   = vx_ff[0];
      start_row = vy_ff[0];
      stop_row  = vy_ff[1];
      walk_down = 1'b1;
      unique case (mode_ff)
         MODE_UPPER_ONLY: begin
            if (pick_b) begin
               dx_s = vx_ff[2];
               dy_m = vy_ff[2];
            end
         end
         MODE_SPLIT_UPPER: begin
            if (pick_b) begin
               dx_s = split_x_ff;
            end
         end
         MODE_LOWER_ONLY: begin
            dx_m      = vx_ff[2];
            dy_m      = vy_ff[2];
            dx_s      = pick_b ? vx_ff[1] : vx_ff[0];
            dy_s      = pick_b ? vy_ff[1] : vy_ff[0];
            start_x   = vx_ff[2];
            start_row = vy_ff[2];
            stop_row  = vy_ff[0];
            walk_down = 1'b0;
         end
         MODE_SPLIT_LOWER: begin
            dx_m      = vx_ff[2];
            dy_m      = vy_ff[2];
            dx_s      = pick_b ? split_x_ff : vx_ff[1];
            dy_s      = vy_ff[1];
            start_x   = vx_ff[2];
            start_row = vy_ff[2];
            stop_row  = vy_ff[1];
            walk_down = 1'b0;
         end
         default: ;
      endcase
   end

   assign slope_dx = DIFF_W'(dx_m) - DIFF_W'(dx_s);
   assign slope_dy = DIFF_W'(dy_m) - DIFF_W'(dy_s);

   // split x = (x0*(y2-y0) + (y1-y0)*(x2-x0)) / (y2-y0), one product a cycle
   assign mul_first = (state_ff == ST_MUL1);
   assign mul_a     = mul_first ? DIFF_W'(vx_ff[0]) : DIFF_W'(vx_ff[2]) - DIFF_W'(vx_ff[0]);
   assign mul_b     = mul_first ? DIFF_W'(vy_ff[2]) - DIFF_W'(vy_ff[0])
                                : DIFF_W'(vy_ff[1]) - DIFF_W'(vy_ff[0]);
   assign mul_prod  = mul_a * mul_b;
   assign split_den = DIFF_W'(vy_ff[2]) - DIFF_W'(vy_ff[0]);

   assign div_start = (state_ff == ST_SPLIT) || (state_ff == ST_SLOPE_A) ||
                      (state_ff == ST_SLOPE_B);
   assign div_num   = (state_ff == ST_SPLIT) ? DIV_NUM_W'(acc_ff)
                                             : (DIV_NUM_W'(slope_dx) <<< FRAC_BITS);
   assign div_den   = (state_ff == ST_SPLIT) ? split_den : slope_dy;

   tsf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      last_part_in = last_part_ff;
      vx_in        = vx_ff;
      vy_in        = vy_ff;
      colour_in    = colour_ff;
      split_x_in   = split_x_ff;
      acc_in       = acc_ff;
      pos_a_in     = pos_a_ff;
      pos_b_in     = pos_b_ff;
      slope_a_in   = slope_a_ff;
      slope_b_in   = slope_b_ff;
      row_in       = row_ff;
      end_row_in   = end_row_ff;
      row_down_in  = row_down_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: ;
         ST_SORT: begin
            for (int i = 0; i < 3; i++) begin
               vx_in[i] = srt_x[2-i];
               vy_in[i] = srt_y[2-i];
            end
            state_in = ST_PLAN;
         end
         ST_PLAN: begin
            if (vy_ff[1] == vy_ff[2]) begin
               mode_in      = MODE_UPPER_ONLY;
               last_part_in = 1'b1;
               state_in     = ST_SLOPE_A;
            end else if (vy_ff[0] == vy_ff[1]) begin
               mode_in      = MODE_LOWER_ONLY;
               last_part_in = 1'b1;
               state_in     = ST_SLOPE_A;
            end else begin
               mode_in      = MODE_SPLIT_UPPER;
               last_part_in = 1'b0;
               state_in     = ST_MUL1;
            end
         end
         ST_MUL1: begin
            acc_in   = ACC_W'(mul_prod);
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            acc_in   = acc_ff + ACC_W'(mul_prod);
            state_in = ST_SPLIT;
         end
         ST_SPLIT: state_in = ST_WAIT_S;
         ST_WAIT_S: begin
            if (div_done) begin
               split_x_in = $signed(div_quo[COORD_BITS-1:0]);
               state_in   = ST_SLOPE_A;
            end
         end
         ST_SLOPE_A: begin
            pos_a_in    = POS_W'(start_x) <<< FRAC_BITS;
            pos_b_in    = POS_W'(start_x) <<< FRAC_BITS;
            row_in      = start_row;
            end_row_in  = stop_row;
            row_down_in = walk_down;
            state_in    = ST_WAIT_A;
         end
         ST_WAIT_A: begin
            if (div_done) begin
               slope_a_in = $signed(div_quo[POS_W-1:0]);
               state_in   = ST_SLOPE_B;
            end
         end
         ST_SLOPE_B: state_in = ST_WAIT_B;
         ST_WAIT_B: begin
            if (div_done) begin
               slope_b_in = $signed(div_quo[POS_W-1:0]);
               state_in   = ST_ACTIVE;
            end
         end
         ST_ACTIVE: begin
            if (span_fire) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.row         = row_ff;
               rsp_data_in.edge_a_x    = pos_to_x(pos_a_ff);
               rsp_data_in.edge_b_x    = pos_to_x(pos_b_ff);
               rsp_data_in.span_colour = colour_ff;
               rsp_data_in.final_span  = last_row && last_part_ff;
               if (last_row) begin
                  if (!last_part_ff) begin
                     // middle row reached: set up the lower part
                     mode_in      = MODE_SPLIT_LOWER;
                     last_part_in = 1'b1;
                     state_in     = ST_SLOPE_A;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  row_in   = row_down_ff ? row_ff - COORD_BITS'(1) : row_ff + COORD_BITS'(1);
                  pos_a_in = pos_a_ff + slope_a_ff;
                  pos_b_in = pos_b_ff + slope_b_ff;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // a start transfer drops any triangle in progress
      if (start_fire) begin
         vx_in[0]  = req_data.ax;
         vy_in[0]  = req_data.ay;
         vx_in[1]  = req_data.bx;
         vy_in[1]  = req_data.by;
         vx_in[2]  = req_data.cx;
         vy_in[2]  = req_data.cy;
         colour_in = req_data.fill_colour;
         state_in  = ST_SORT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      last_part_ff <= last_part_in;
      vx_ff        <= vx_in;
      vy_ff        <= vy_in;
      colour_ff    <= colour_in;
      split_x_ff   <= split_x_in;
      acc_ff       <= acc_in;
      pos_a_ff     <= pos_a_in;
      pos_b_ff     <= pos_b_in;
      slope_a_ff   <= slope_a_in;
      slope_b_ff   <= slope_b_in;
      row_ff       <= row_in;
      end_row_ff   <= end_row_in;
      row_down_ff  <= row_down_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `TSF_ASSERT_NEXT(a_final_span_idles, clock, reset, span_fire && last_row && last_part_ff, state_ff == ST_IDLE, "final span did not return the sequencer to idle")
   `TSF_ASSERT_IMP(a_div_done_awaited, clock, reset, div_done, (state_ff == ST_WAIT_S) || (state_ff == ST_WAIT_A) || (state_ff == ST_WAIT_B), "divider finished outside a wait state")
   `TSF_ASSERT_IMP(a_span_slot_free, clock, reset, span_fire, !rsp_valid_ff || !rsp_stall, "span written over a held transfer")

endmodule

`default_nettype wire

FILE: dv/tsf_span_checker.sv
// ----------------------------------------------------------------------------
// tsf_span_checker
// Watches the request and span channels of the triangle span generator. It
// keeps its own copy of the triangle walk, queues the span due for every
// accepted advance transfer while a triangle is being walked and compares each span that leaves the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsf_span_checker
   import tsf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  tsf_req_type req_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  tsf_rsp_type rsp_data,
   output int          error_count,
   output int          spans_pending,
   output int          spans_checked,
   output int          triangles_loaded
);

   typedef enum logic [1:0] {
      FILL_IDLE,
      FILL_UPPER_FIRST,
      FILL_LAST_PART
   } fill_phase_type;

   logic signed [COORD_BITS-1:0] corner_x [3];
   logic signed [COORD_BITS-1:0] corner_y [3];
   logic signed [POS_W-1:0]      edge_a_pos;
   logic signed [POS_W-1:0]      edge_b_pos;
   logic signed [POS_W-1:0]      slope_a;
   logic signed [POS_W-1:0]      slope_b;
   logic signed [COORD_BITS-1:0] row_now;
   logic signed [COORD_BITS-1:0] row_last;
   int                           row_step;
   int                           split_x;
   fill_phase_type               fill_phase;
   logic [COLOUR_W-1:0]          colour_held;
   tsf_rsp_type                  expected_spans [$];

   // per-row x step, truncated toward zero; a flat edge steps by nothing
   function automatic logic signed [POS_W-1:0] inverse_slope(input int dx, input int dy);
      if (dy == 0) begin
         return '0;
      end
      return POS_W'((longint'(dx) <<< FRAC_BITS) / longint'(dy));
   endfunction

   function automatic logic signed [POS_W-1:0] pixel_to_pos(input int x);
      return POS_W'(longint'(x) <<< FRAC_BITS);
   endfunction

   // walk downward from the top corner to the middle row
   task automatic setup_upper(input int x0, y0, x1, y1, x2, y2);
      slope_a    = -inverse_slope(x1 - x0, y1 - y0);
      slope_b    = -inverse_slope(x2 - x0, y2 - y0);
      edge_a_pos = pixel_to_pos(x0);
      edge_b_pos = pixel_to_pos(x0);
      row_now    = COORD_BITS'(y0);
      row_last   = COORD_BITS'(y1);
      row_step   = -1;
   endtask

   // walk upward from the bottom corner
   task automatic setup_lower(input int x0, y0, x1, y1, x2, y2);
      slope_a    = inverse_slope(x2 - x0, y2 - y0);
      slope_b    = inverse_slope(x2 - x1, y2 - y1);
      edge_a_pos = pixel_to_pos(x2);
      edge_b_pos = pixel_to_pos(x2);
      row_now    = COORD_BITS'(y2);
      row_last   = COORD_BITS'(y0);
      row_step   = 1;
   endtask

   task automatic load_triangle(input tsf_req_type r);
      int     px [3];
      int     py [3];
      int     t;
      longint dy;
      longint num;
      px[0] = r.ax; py[0] = r.ay;
      px[1] = r.bx; py[1] = r.by;
      px[2] = r.cx; py[2] = r.cy;
      colour_held = r.fill_colour;
      triangles_loaded++;

      // three-element sort by y, then top and bottom corners traded
      if (py[0] > py[1]) begin
         t = px[0]; px[0] = px[1]; px[1] = t;
         t = py[0]; py[0] = py[1]; py[1] = t;
      end
      if (py[1] > py[2]) begin
         t = px[1]; px[1] = px[2]; px[2] = t;
         t = py[1]; py[1] = py[2]; py[2] = t;
         if (py[0] > py[1]) begin
            t = px[0]; px[0] = px[1]; px[1] = t;
            t = py[0]; py[0] = py[1]; py[1] = t;
         end
      end
      t = px[0]; px[0] = px[2]; px[2] = t;
      t = py[0]; py[0] = py[2]; py[2] = t;

      for (int i = 0; i < 3; i++) begin
         corner_x[i] = COORD_BITS'(px[i]);
         corner_y[i] = COORD_BITS'(py[i]);
      end

      if (py[1] == py[2]) begin
         setup_upper(px[0], py[0], px[1], py[1], px[2], py[2]);
         fill_phase = FILL_LAST_PART;
      end else if (py[0] == py[1]) begin
         setup_lower(px[0], py[0], px[1], py[1], px[2], py[2]);
         fill_phase = FILL_LAST_PART;
      end else begin
         // split point on the long edge at the middle row
         dy  = longint'(py[2]) - py[0];
         num = longint'(px[0]) * dy + (longint'(py[1]) - py[0]) * (longint'(px[2]) - px[0]);
         split_x = int'(num / dy);
         setup_upper(px[0], py[0], px[1], py[1], split_x, py[1]);
         fill_phase = FILL_UPPER_FIRST;
      end
   endtask

   task automatic predict_span();
      tsf_rsp_type span;
      logic        at_end;
      if (fill_phase != FILL_IDLE) begin
         at_end           = (row_now == row_last);
         span.row         = row_now;
         span.edge_a_x    = COORD_BITS'(longint'(edge_a_pos) / (longint'(1) <<< FRAC_BITS));
         span.edge_b_x    = COORD_BITS'(longint'(edge_b_pos) / (longint'(1) <<< FRAC_BITS));
         span.span_colour = colour_held;
         span.final_span  = at_end && (fill_phase == FILL_LAST_PART);
         expected_spans.push_back(span);
         if (at_end) begin
            if (fill_phase == FILL_UPPER_FIRST) begin
               setup_lower(corner_x[1], corner_y[1], split_x, corner_y[1],
                           corner_x[2], corner_y[2]);
               fill_phase = FILL_LAST_PART;
            end else begin
               fill_phase = FILL_IDLE;
            end
         end else begin
            row_now    = COORD_BITS'(row_now + row_step);
            edge_a_pos = edge_a_pos + slope_a;
            edge_b_pos = edge_b_pos + slope_b;
         end
      end
   endtask

   task automatic report_mismatch(input string text);
      $display("[%0t] span check: %s", $time, text);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic signed [63:0] got,
                              input logic signed [63:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("span %0d %s: got %0d, expected %0d",
                                   spans_checked, name, got, want));
      end
   endtask

   task automatic compare_span(input tsf_rsp_type got);
      tsf_rsp_type want;
      if (expected_spans.size() == 0) begin
         report_mismatch($sformatf("span row %0d arrived with none outstanding", got.row));
      end else begin
         want = expected_spans.pop_front();
         spans_checked++;
         check_field("row", got.row, want.row);
         check_field("edge_a_x", got.edge_a_x, want.edge_a_x);
         check_field("edge_b_x", got.edge_b_x, want.edge_b_x);
         check_field("span_colour", got.span_colour, want.span_colour);
         check_field("final_span", got.final_span, want.final_span);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            corner_x[i] = '0;
            corner_y[i] = '0;
         end
         edge_a_pos       = '0;
         edge_b_pos       = '0;
         slope_a          = '0;
         slope_b          = '0;
         row_now          = '0;
         row_last         = '0;
         row_step         = 0;
         split_x          = 0;
         fill_phase       = FILL_IDLE;
         colour_held      = '0;
         error_count      = 0;
         spans_checked    = 0;
         triangles_loaded = 0;
         expected_spans.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            compare_span(rsp_data);
         end
         if (req_valid && !req_stall) begin
            if (req_data.action == ACT_START) begin
               load_triangle(req_data);
            end else begin
               predict_span();
            end
         end
      end
      spans_pending = expected_spans.size();
   end

endmodule

FILE: dv/tb_triangle_scanline_fill_core.sv
// ----------------------------------------------------------------------------
// tb_triangle_scanline_fill_core
// Drives start and advance transfers into the span generator: a directed
// opening with flat, degenerate, extreme and split triangles, then random
// triangles under four idling regimes and one long output hold-off.
// Checking is done by the span checker alongside the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_triangle_scanline_fill_core;
   import tsf_pkg::*;

   localparam int REQ_W          = $bits(tsf_req_type);
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 300;
   localparam int HOLD_OFF       = 400;
   localparam int PHASE_ITEMS    = 360;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   tsf_req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   tsf_rsp_type rsp_data;

   int error_count;
   int spans_pending;
   int spans_checked;
   int triangles_loaded;

   int send_idle_pct     = 0;
   int rsp_stall_pct     = 0;
   int long_hold_cycles  = 0;
   int requests_sent     = 0;
   int quiet_cycles      = 0;

   always #5 clock = ~clock;

   triangle_scanline_fill_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   tsf_span_checker span_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .error_count      (error_count),
      .spans_pending    (spans_pending),
      .spans_checked    (spans_checked),
      .triangles_loaded (triangles_loaded)
   );

   // span sink: random stalls, plus a long hold-off when asked
   initial begin : span_sink
      int hold;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_cycles > 0) begin
            hold = long_hold_cycles;
            long_hold_cycles = 0;
            repeat (hold) begin
               rsp_stall <= 1'b1;
               @(negedge clock);
            end
         end
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // entered and left at a falling edge; valid stays up between back-to-back items
   task automatic send_req(input tsf_req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic send_start(input int ax, ay, bx, by, cx, cy, input logic [31:0] colour);
      tsf_req_type item;
      item.action      = ACT_START;
      item.ax          = COORD_BITS'(ax);
      item.ay          = COORD_BITS'(ay);
      item.bx          = COORD_BITS'(bx);
      item.by          = COORD_BITS'(by);
      item.cx          = COORD_BITS'(cx);
      item.cy          = COORD_BITS'(cy);
      item.fill_colour = colour;
      send_req(item);
   endtask

   // the vertex fields of an advance carry noise, the block ignores them
   task automatic send_advances(input int count);
      tsf_req_type item;
      repeat (count) begin
         item        = tsf_req_type'(REQ_W'({$urandom, $urandom, $urandom, $urandom}));
         item.action = ACT_ADVANCE;
         send_req(item);
      end
   endtask

   task automatic send_random_triangle();
      int spread_x, spread_y, base_x, base_y;
      int lo, hi, mid, spans, count;
      int vx [3];
      int vy [3];
      spread_y = ($urandom_range(39) == 0) ? $urandom_range(40) : $urandom_range(6);
      spread_x = ($urandom_range(1) == 0) ? 4095 : $urandom_range(30);
      base_y   = $urandom_range(4095 - spread_y) - 2048;
      base_x   = $urandom_range(4095 - spread_x) - 2048;
      for (int i = 0; i < 3; i++) begin
         vx[i] = base_x + $urandom_range(spread_x);
         vy[i] = base_y + $urandom_range(spread_y);
      end
      lo = vy[0]; hi = vy[0];
      for (int i = 1; i < 3; i++) begin
         if (vy[i] < lo) lo = vy[i];
         if (vy[i] > hi) hi = vy[i];
      end
      mid = vy[0] + vy[1] + vy[2] - lo - hi;
      // a split triangle gives its middle row twice
      spans = hi - lo + ((mid != lo && mid != hi) ? 2 : 1);
      // mostly the whole walk, sometimes one idle advance, now and then abandoned
      count = ($urandom_range(9) == 0) ? $urandom_range(spans) : spans + $urandom_range(1);
      send_start(vx[0], vy[0], vx[1], vy[1], vx[2], vy[2], $urandom);
      send_advances(count);
   endtask

   initial begin : stimulus
      int idle_send [4];
      int idle_rsp  [4];
      int goal;
      idle_send = '{0, 85, 0, 17};
      idle_rsp  = '{0, 0, 85, 17};
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // advance with nothing loaded
      send_advances(1);
      // all three corners on one row
      send_start(5, 7, -3, 7, 100, 7, 32'h1234_5678);
      send_advances(2);
      // corners at the coordinate limits, abandoned part way by the next start
      send_start(-2048, -2048, 2047, 2047, 2047, -2048, 32'hFFFF_FFFF);
      send_advances(3);
      // flat top: lower part only
      send_start(0, 3, 6, 3, 3, 0, 32'hA5A5_0F0F);
      send_advances(4);
      // flat bottom: upper part only
      send_start(0, 3, -5, 0, 5, 0, 32'h5A5A_F0F0);
      send_advances(4);
      // general triangle split at the middle corner
      send_start(0, 0, 4, 2, -3, -2, 32'h0000_0000);
      send_advances(6);

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = idle_send[phase];
         rsp_stall_pct = idle_rsp[phase];
         if (phase == 0) begin
            long_hold_cycles = HOLD_OFF;
         end
         goal = requests_sent + PHASE_ITEMS;
         while (requests_sent < goal) begin
            if ($urandom_range(99) < 8) begin
               send_req(tsf_req_type'(REQ_W'({$urandom, $urandom, $urandom, $urandom})));
            end else begin
               send_random_triangle();
            end
         end
      end

      req_valid <= 1'b0;
      while (spans_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Coverage: %0d request transfers over four idling regimes and one long hold-off.",
               requests_sent);
      $display("Coverage: %0d triangles loaded, %0d spans compared.",
               triangles_loaded, spans_checked);
      if (error_count == 0 && spans_pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
